// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spfx_pkg.sv =====
`timescale 1ns / 1ps

package spfx_pkg;

    localparam int SAMPLES_PER_FRAME = 256;
    localparam int POS_W = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;

    localparam int SAMPLE_W = 16;
    localparam int SEQ_W    = 32;
    localparam int TS_W     = 32;
    localparam int FLAGS_W  = 8;
    localparam int CSUM_W   = 16;
    localparam int IN_DATA_W = SAMPLE_W + SEQ_W + TS_W + FLAGS_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HDR_BYTE0 = 8'hAA;
    localparam logic [7:0] HDR_BYTE1 = 8'h55;
    localparam logic [7:0] PAD_BYTE  = 8'h00;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_HDR0    = 4'd0;
    localparam logic [STEP_W-1:0] STEP_HDR1    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SEQ0    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SEQ1    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SEQ2    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SEQ3    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_TS0     = 4'd6;
    localparam logic [STEP_W-1:0] STEP_TS1     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_TS2     = 4'd8;
    localparam logic [STEP_W-1:0] STEP_TS3     = 4'd9;
    localparam logic [STEP_W-1:0] STEP_FLAGS   = 4'd10;
    localparam logic [STEP_W-1:0] STEP_PAD     = 4'd11;
    localparam logic [STEP_W-1:0] STEP_SMP_LO  = 4'd12;
    localparam logic [STEP_W-1:0] STEP_SMP_HI  = 4'd13;
    localparam logic [STEP_W-1:0] STEP_CSUM_LO = 4'd14;
    localparam logic [STEP_W-1:0] STEP_CSUM_HI = 4'd15;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [SEQ_W-1:0]    sequence_number;
        logic [TS_W-1:0]     timestamp;
        logic [FLAGS_W-1:0]  frame_flags;
        logic                first;
        logic                last;
        logic [CSUM_W-1:0]   checksum;
    } spfx_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spfx_qstat_t;

    function automatic logic [7:0] frame_byte(spfx_entry_t e, logic [STEP_W-1:0] step);
        logic [7:0] b;
        case (step)
            STEP_HDR0:    b = HDR_BYTE0;
            STEP_HDR1:    b = HDR_BYTE1;
            STEP_SEQ0:    b = e.sequence_number[7:0];
            STEP_SEQ1:    b = e.sequence_number[15:8];
            STEP_SEQ2:    b = e.sequence_number[23:16];
            STEP_SEQ3:    b = e.sequence_number[31:24];
            STEP_TS0:     b = e.timestamp[7:0];
            STEP_TS1:     b = e.timestamp[15:8];
            STEP_TS2:     b = e.timestamp[23:16];
            STEP_TS3:     b = e.timestamp[31:24];
            STEP_FLAGS:   b = e.frame_flags;
            STEP_PAD:     b = PAD_BYTE;
            STEP_SMP_LO:  b = e.sample[7:0];
            STEP_SMP_HI:  b = e.sample[15:8];
            STEP_CSUM_LO: b = e.checksum[7:0];
            STEP_CSUM_HI: b = e.checksum[15:8];
            default:      b = PAD_BYTE;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/sample_frame_packetizer_xor_unit.sv =====
`timescale 1ns / 1ps

// Sample frame packetizer with XOR checksum.
// s_axis: one 16-bit sample per beat, with the frame's sequence number, timestamp
//   and flags beside it; those three are read only on the first sample of a frame.
// m_axis: one byte per beat. The first sample of a frame yields AA 55, sequence,
//   timestamp, flags, a zero pad and the sample (14 beats); later samples yield two
//   beats; the last sample adds the 16-bit checksum, tlast on its high byte.
// The first byte of an item passes through the queue and then the output register.
// Throughput: the byte output runs one beat per cycle while m_axis_tready is high; a
//   two-entry queue between the input side and the serializer keeps the input open
//   while bytes are still going out.
// Reset puts the block at the start of a frame with the checksum cleared and the
//   queue empty; m_axis_tvalid is low.
// When m_axis_tready is low the current byte holds, the serializer stops, and
//   s_axis_tready drops once the queue holds two samples.
module sample_frame_packetizer_xor_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample[15:0], sequence_number[47:16], timestamp[79:48], frame_flags[87:80]
    input  logic [spfx_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_byte[7:0]
    output logic [7:0]                     m_axis_tdata,
    output logic                           m_axis_tlast
);

    spfx_pkg::spfx_entry_t entry;
    spfx_pkg::spfx_entry_t head;
    spfx_pkg::spfx_qstat_t qstat;
    logic                  push;
    logic                  pop;

    spfx_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .qstat    (qstat),
        .push     (push),
        .entry    (entry)
    );

    spfx_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .entry_in (entry),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    spfx_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== rtl/spfx_front.sv =====
`timescale 1ns / 1ps

module spfx_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [spfx_pkg::IN_DATA_W-1:0]     in_data,
    input  spfx_pkg::spfx_qstat_t              qstat,
    output logic                               push,
    output spfx_pkg::spfx_entry_t              entry
);

    logic [spfx_pkg::POS_W-1:0]  pos_reg;
    logic [spfx_pkg::POS_W-1:0]  pos_next;
    logic [spfx_pkg::CSUM_W-1:0] csum_reg;
    logic [spfx_pkg::CSUM_W-1:0] csum_next;

    logic [spfx_pkg::SAMPLE_W-1:0] sample;
    logic [spfx_pkg::SEQ_W-1:0]    sequence_number;
    logic [spfx_pkg::TS_W-1:0]     timestamp;
    logic [spfx_pkg::FLAGS_W-1:0]  frame_flags;
    logic                          first;
    logic                          last;
    logic [spfx_pkg::CSUM_W-1:0]   csum_base;
    logic [spfx_pkg::CSUM_W-1:0]   csum_new;

    assign sample          = in_data[15:0];
    assign sequence_number = in_data[47:16];
    assign timestamp       = in_data[79:48];
    assign frame_flags     = in_data[87:80];

    assign in_ready = !qstat.full;
    assign push     = in_valid && in_ready;

    assign first = (pos_reg == '0);
    assign last  = (pos_reg == spfx_pkg::POS_W'(spfx_pkg::SAMPLES_PER_FRAME - 1));

    always_comb
    begin
        if (first)
        begin
            csum_base = sequence_number[15:0] ^ sequence_number[31:16]
                      ^ timestamp[15:0] ^ timestamp[31:16]
                      ^ {8'h00, frame_flags};
        end
        else
        begin
            csum_base = csum_reg;
        end
        csum_new = csum_base ^ sample;
    end

    always_comb
    begin
        entry.sample          = sample;
        entry.sequence_number = sequence_number;
        entry.timestamp       = timestamp;
        entry.frame_flags     = frame_flags;
        entry.first           = first;
        entry.last            = last;
        entry.checksum        = csum_new;
    end

    always_comb
    begin
        pos_next  = pos_reg;
        csum_next = csum_reg;
        if (push)
        begin
            csum_next = csum_new;
            pos_next  = last ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            csum_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            csum_reg <= csum_next;
        end
    end

endmodule

// ===== rtl/spfx_queue.sv =====
`timescale 1ns / 1ps

module spfx_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  spfx_pkg::spfx_entry_t entry_in,
    input  logic                  pop,
    output spfx_pkg::spfx_entry_t head,
    output spfx_pkg::spfx_qstat_t qstat
);

    spfx_pkg::spfx_entry_t slot_reg [spfx_pkg::QUEUE_DEPTH];

    logic [spfx_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [spfx_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [spfx_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [spfx_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [spfx_pkg::QCNT_W-1:0] cnt_reg;
    logic [spfx_pkg::QCNT_W-1:0] cnt_next;

    localparam logic [spfx_pkg::QPTR_W-1:0] PTR_LAST =
        spfx_pkg::QPTR_W'(spfx_pkg::QUEUE_DEPTH - 1);

    assign head        = slot_reg[rd_ptr_reg];
    assign qstat.empty = (cnt_reg == '0);
    assign qstat.full  = (cnt_reg == spfx_pkg::QCNT_W'(spfx_pkg::QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

// ===== rtl/spfx_back.sv =====
`timescale 1ns / 1ps

module spfx_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  spfx_pkg::spfx_entry_t head,
    input  spfx_pkg::spfx_qstat_t qstat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_data,
    output logic                  out_last
);

    logic                        fresh_reg;
    logic                        fresh_next;
    logic [spfx_pkg::STEP_W-1:0] step_reg;
    logic [spfx_pkg::STEP_W-1:0] step_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic [7:0]                  data_reg;
    logic [7:0]                  data_next;
    logic                        last_reg;
    logic                        last_next;

    logic [spfx_pkg::STEP_W-1:0] cur_step;
    logic [spfx_pkg::STEP_W-1:0] end_step;
    logic                        load;

    assign cur_step = fresh_reg ? (head.first ? spfx_pkg::STEP_HDR0 : spfx_pkg::STEP_SMP_LO)
                                : step_reg;
    assign end_step = head.last ? spfx_pkg::STEP_CSUM_HI : spfx_pkg::STEP_SMP_HI;
    assign load     = !qstat.empty && (!valid_reg || out_ready);
    assign pop      = load && (cur_step == end_step);

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

    always_comb
    begin
        fresh_next = fresh_reg;
        step_next  = step_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = spfx_pkg::frame_byte(head, cur_step);
            last_next  = (cur_step == spfx_pkg::STEP_CSUM_HI);
            if (cur_step == end_step)
            begin
                fresh_next = 1'b1;
            end
            else
            begin
                fresh_next = 1'b0;
                step_next  = cur_step + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= 1'b1;
            step_reg  <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            fresh_reg <= fresh_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== rtl/spfx_checker.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module spfx_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    typedef enum logic [1:0] {
        CHK_HDR0,
        CHK_HDR1,
        CHK_BODY
    } chk_pos_t;

    chk_pos_t pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= CHK_HDR0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            if (m_axis_tlast)
            begin
                pos_reg <= CHK_HDR0;
            end
            else
            begin
                case (pos_reg)
                    CHK_HDR0: pos_reg <= CHK_HDR1;
                    CHK_HDR1: pos_reg <= CHK_BODY;
                    default:  pos_reg <= pos_reg;
                endcase
            end
        end
    end

    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output beat changed")

    `ASSERT_IMPLY(a_frame_hdr0, m_axis_tvalid && (pos_reg == CHK_HDR0), (m_axis_tdata == spfx_pkg::HDR_BYTE0) && !m_axis_tlast, "frame does not open with first header byte")

    `ASSERT_IMPLY(a_frame_hdr1, m_axis_tvalid && (pos_reg == CHK_HDR1), (m_axis_tdata == spfx_pkg::HDR_BYTE1) && !m_axis_tlast, "second header byte missing")

endmodule

bind sample_frame_packetizer_xor_unit spfx_checker u_spfx_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/spfx_frame_checker.sv =====
`timescale 1ns / 1ps

module spfx_frame_checker
    import spfx_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [7:0]           m_axis_tdata,
    input  logic                 m_axis_tlast,
    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_end;
    } frame_beat_t;

    frame_beat_t       frame_bytes_due[$];
    int                next_sample_pos = 0;
    logic [CSUM_W-1:0] frame_xor = '0;
    int                bad_beats = 0;

    task automatic push_byte(input logic [7:0] b, input logic is_end);
        frame_beat_t fb;
        fb.data_byte = b;
        fb.is_end    = is_end;
        frame_bytes_due.push_back(fb);
    endtask

    task automatic push_word32(input logic [31:0] w);
        push_byte(w[7:0], 1'b0);
        push_byte(w[15:8], 1'b0);
        push_byte(w[23:16], 1'b0);
        push_byte(w[31:24], 1'b0);
    endtask

    task automatic packetize_sample(input logic [IN_DATA_W-1:0] beat_in);
        logic [SAMPLE_W-1:0] smp;
        logic [SEQ_W-1:0]    seq;
        logic [TS_W-1:0]     ts;
        logic [FLAGS_W-1:0]  flg;
        smp = beat_in[15:0];
        seq = beat_in[47:16];
        ts  = beat_in[79:48];
        flg = beat_in[87:80];
        if (next_sample_pos == 0)
        begin
            frame_xor = seq[15:0] ^ seq[31:16] ^ ts[15:0] ^ ts[31:16] ^ {8'h00, flg};
            push_byte(HDR_BYTE0, 1'b0);
            push_byte(HDR_BYTE1, 1'b0);
            push_word32(seq);
            push_word32(ts);
            push_byte(flg, 1'b0);
            push_byte(PAD_BYTE, 1'b0);
        end
        frame_xor = frame_xor ^ smp;
        push_byte(smp[7:0], 1'b0);
        push_byte(smp[15:8], 1'b0);
        if (next_sample_pos >= SAMPLES_PER_FRAME - 1)
        begin
            push_byte(frame_xor[7:0], 1'b0);
            push_byte(frame_xor[15:8], 1'b1);
            next_sample_pos = 0;
        end
        else
        begin
            next_sample_pos++;
        end
    endtask

    task automatic compare_byte(input logic [7:0] got_byte, input logic got_end);
        frame_beat_t want;
        if (frame_bytes_due.size() == 0)
        begin
            bad_beats++;
            if (bad_beats <= 10)
                $display("unexpected output beat: byte=%h tlast=%b", got_byte, got_end);
        end
        else
        begin
            want = frame_bytes_due.pop_front();
            if (want.data_byte !== got_byte || want.is_end !== got_end)
            begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("output beat mismatch: expected byte=%h tlast=%b, got byte=%h tlast=%b",
                             want.data_byte, want.is_end, got_byte, got_end);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                packetize_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                compare_byte(m_axis_tdata, m_axis_tlast);
        end
        mismatches  <= bad_beats;
        outstanding <= frame_bytes_due.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import spfx_pkg::*;

    localparam int NUM_ITEMS = SAMPLES_PER_FRAME + 8;
    localparam int LONG_HOLD = 400;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tready = 1'b0;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;
    int                   mismatches;
    int                   outstanding;

    sample_frame_packetizer_xor_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    spfx_frame_checker frame_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [IN_DATA_W-1:0] make_sample_beat(input int idx);
        logic [SAMPLE_W-1:0] smp;
        logic [SEQ_W-1:0]    seq;
        logic [TS_W-1:0]     ts;
        logic [FLAGS_W-1:0]  flg;
        int                  pos;
        int                  frame_idx;
        pos       = idx % SAMPLES_PER_FRAME;
        frame_idx = idx / SAMPLES_PER_FRAME;
        smp = SAMPLE_W'($urandom);
        seq = SEQ_W'($urandom);
        ts  = TS_W'($urandom);
        flg = FLAGS_W'($urandom);
        if (idx < 25)
        begin
            case (idx)
                0:       smp = 16'h0000;
                1:       smp = 16'hFFFF;
                2:       smp = 16'h00FF;
                3:       smp = 16'hFF00;
                22:      smp = 16'h5555;
                23:      smp = 16'hAAAA;
                24:      smp = 16'hFFFF;
                default: smp = 16'h0001 << (idx - 4);
            endcase
            // header fields on later samples must be dropped
            if (idx % 2 == 0)
            begin
                seq = '1;
                ts  = '1;
                flg = '1;
            end
            else
            begin
                seq = '0;
                ts  = '0;
                flg = '0;
            end
        end
        else if (pos == 0)
        begin
            case (frame_idx)
                1:
                begin
                    smp = 16'hFFFF;
                    seq = '0;
                    ts  = '0;
                    flg = '0;
                end
                2:
                begin
                    seq = 32'h5555_AAAA;
                    ts  = 32'hAAAA_5555;
                    flg = 8'hA5;
                end
                default: ;
            endcase
        end
        return {flg, ts, seq, smp};
    endfunction

    initial
    begin
        int  gap;
        int  waited;
        bit  quiet_tx;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < NUM_ITEMS; i++)
        begin
            if (i % 64 == 0)
                quiet_tx = ($urandom_range(0, 3) == 0);
            gap = quiet_tx ? 0 : $urandom_range(0, 13);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= make_sample_beat(i);
            do @(posedge clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < 20000);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int  stall;
        int  beats;
        bit  quiet_rx;
        bit  held;
        beats = 0;
        held  = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (beats % 128 == 0)
                quiet_rx = ($urandom_range(0, 3) == 0);
            stall = quiet_rx ? 0 : $urandom_range(0, 13);
            // hold off long enough for the input side to back up
            if (!held && beats == 300)
            begin
                stall = LONG_HOLD;
                held  = 1'b1;
            end
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            beats++;
        end
    end

endmodule
